FILE: src/fte_pkg.sv
// Package with types, codes and sizes shared by the frame timer event table.
`timescale 1ns / 1ps
`default_nettype none
package fte_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_QUERY  = 3'd2;
  localparam logic [2:0] KIND_FIRED  = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_DELAY = 2'd2;
  localparam logic [1:0] ST_NO_HANDLE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] frame;
    logic [31:0] object_id;
    logic [15:0] event_code;
    logic [31:0] delay_frames;
    logic [31:0] already_elapsed;
    logic [5:0]  slot_handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [5:0]  handle_out;
    logic [31:0] fired_object;
    logic [15:0] fired_code;
    logic        is_active;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] object_id;
    logic [15:0] event_code;
    logic [31:0] due;
  } entry_t;

  typedef struct packed {
    logic             ent_we;
    logic [IDX_W-1:0] ent_waddr;
    entry_t           ent_wdata;
    logic [IDX_W-1:0] ent_raddr;
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    logic [IDX_W-1:0] ord_wdata;
    logic [IDX_W-1:0] ord_raddr;
  } store_req_t;

endpackage
`default_nettype wire

FILE: src/fte_store.sv
// Entry memory and insertion-order memory, each one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fte_store import fte_pkg::*; (
  input  wire logic             clk_i,
  input  wire store_req_t       req_i,
  output logic      [IDX_W-1:0] ord_rdata_o,
  output entry_t                ent_rdata_o
);

  entry_t           ent_mem [TABLE_DEPTH];
  logic [IDX_W-1:0] ord_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.ent_we) begin
      ent_mem[req_i.ent_waddr] <= req_i.ent_wdata;
    end
    ent_rdata_o <= ent_mem[req_i.ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ord_we) begin
      ord_mem[req_i.ord_waddr] <= req_i.ord_wdata;
    end
    ord_rdata_o <= ord_mem[req_i.ord_raddr];
  end

endmodule
`default_nettype wire

FILE: src/frame_timer_event_table.sv
// Top level of the frame timer event table: command control, valid bits and result register.
`timescale 1ns / 1ps
`default_nettype none
// Add and a rejected remove are answered straight from the idle state. A remove walks the
// insertion-order memory at one entry per cycle. A query reads every slot of the entry
// memory. A tick reads the order memory and then the entry memory for each live entry,
// and waits while a fired-event transfer waits on out_ready_i. One command is in work at a time.
module frame_timer_event_table import fte_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ORD_CHK = 3'd1;
  localparam logic [2:0] S_ENT_CHK = 3'd2;
  localparam logic [2:0] S_FIN     = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic [IDX_W-1:0]       slot_q, slot_d;
  logic                   found_q, found_d;
  in_item_t               cur_q, cur_d;
  out_item_t              out_q, out_d;
  logic                   out_valid_q;
  logic                   out_load;
  logic                   out_free;

  store_req_t       req;
  logic [IDX_W-1:0] ord_rdata;
  entry_t           ent_rdata;

  logic [IDX_W-1:0] free_slot;
  logic [IDX_W-1:0] i_idx;
  logic [IDX_W-1:0] i_next;
  logic             scan_end;
  logic             hit;

  fte_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .ord_rdata_o (ord_rdata),
    .ent_rdata_o (ent_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign i_idx = i_q[IDX_W-1:0];
  assign i_next = IDX_W'(i_q + CNT_W'(1));
  assign scan_end = (i_q + CNT_W'(1)) == count_q;
  assign hit = valid_q[slot_q] && (ent_rdata.due == cur_q.frame);

  // Lowest free slot.
  always_comb begin
    free_slot = '0;
    for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_slot = IDX_W'(k);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    count_d  = count_q;
    i_d      = i_q;
    j_d      = j_q;
    slot_d   = slot_q;
    found_d  = found_q;
    cur_d    = cur_q;
    out_load = 1'b0;
    out_d    = '0;

    req           = '0;
    req.ent_raddr = '0;
    req.ord_raddr = '0;
    req.ent_wdata.object_id  = in_item_i.object_id;
    req.ent_wdata.event_code = in_item_i.event_code;
    req.ent_wdata.due = in_item_i.frame - in_item_i.already_elapsed + in_item_i.delay_frames;
    req.ent_waddr = free_slot;
    req.ord_waddr = count_q[IDX_W-1:0];
    req.ord_wdata = free_slot;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cur_d   = in_item_i;
          i_d     = '0;
          j_d     = '0;
          found_d = 1'b0;
          out_d.last = 1'b1;
          case (in_item_i.cmd)
            CMD_ADD: begin
              out_load   = 1'b1;
              out_d.kind = KIND_ADD;
              if (count_q == CNT_W'(TABLE_DEPTH)) begin
                out_d.status = ST_FULL;
              end else if (in_item_i.delay_frames == '0 ||
                           in_item_i.already_elapsed > in_item_i.delay_frames) begin
                out_d.status = ST_BAD_DELAY;
              end else begin
                out_d.status     = ST_OK;
                out_d.handle_out = 6'(free_slot);
                req.ent_we       = 1'b1;
                req.ord_we       = 1'b1;
                valid_d[free_slot] = 1'b1;
                count_d          = count_q + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (in_item_i.slot_handle >= 6'(TABLE_DEPTH) ||
                  !valid_q[in_item_i.slot_handle[IDX_W-1:0]]) begin
                out_load     = 1'b1;
                out_d.kind   = KIND_REMOVE;
                out_d.status = ST_NO_HANDLE;
              end else begin
                valid_d[in_item_i.slot_handle[IDX_W-1:0]] = 1'b0;
                state_d = S_ORD_CHK;
              end
            end
            CMD_QUERY: begin
              state_d = S_ENT_CHK;
            end
            default: begin
              state_d = (count_q == '0) ? S_FIN : S_ORD_CHK;
            end
          endcase
        end
      end

      S_ORD_CHK: begin
        if (cur_q.cmd == CMD_REMOVE) begin
          // Compact the order list in place; writes trail the reads.
          if (ord_rdata != cur_q.slot_handle[IDX_W-1:0]) begin
            req.ord_we    = 1'b1;
            req.ord_waddr = j_q[IDX_W-1:0];
            req.ord_wdata = ord_rdata;
            j_d = j_q + CNT_W'(1);
          end
          req.ord_raddr = i_next;
          i_d = i_q + CNT_W'(1);
          if (scan_end) begin
            state_d = S_FIN;
          end
        end else begin
          req.ent_raddr = ord_rdata;
          slot_d  = ord_rdata;
          state_d = S_ENT_CHK;
        end
      end

      S_ENT_CHK: begin
        if (cur_q.cmd == CMD_QUERY) begin
          if (valid_q[i_idx] && ent_rdata.object_id == cur_q.object_id &&
              ent_rdata.event_code == cur_q.event_code) begin
            found_d = 1'b1;
          end
          req.ent_raddr = i_next;
          i_d = i_q + CNT_W'(1);
          if (i_q == CNT_W'(TABLE_DEPTH - 1)) begin
            state_d = S_FIN;
          end
        end else begin
          req.ent_raddr = slot_q;
          req.ord_raddr = i_next;
          if (!hit || out_free) begin
            if (hit) begin
              out_load           = 1'b1;
              out_d.kind         = KIND_FIRED;
              out_d.status       = ST_OK;
              out_d.handle_out   = 6'(slot_q);
              out_d.fired_object = ent_rdata.object_id;
              out_d.fired_code   = ent_rdata.event_code;
              valid_d[slot_q]    = 1'b0;
            end else begin
              req.ord_we    = 1'b1;
              req.ord_waddr = j_q[IDX_W-1:0];
              req.ord_wdata = slot_q;
              j_d = j_q + CNT_W'(1);
            end
            i_d = i_q + CNT_W'(1);
            state_d = scan_end ? S_FIN : S_ORD_CHK;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          case (cur_q.cmd)
            CMD_REMOVE: begin
              out_d.kind = KIND_REMOVE;
              count_d    = j_q;
            end
            CMD_QUERY: begin
              out_d.kind      = KIND_QUERY;
              out_d.is_active = found_q;
            end
            default: begin
              out_d.kind = KIND_DONE;
              count_d    = j_q;
            end
          endcase
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    cur_q   <= cur_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (32'(count_q) == 32'($countones(valid_q))))
    else $error("entry count disagrees with valid bits");

  a_fired_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.kind == KIND_FIRED) |=> !valid_q[$past(slot_q)])
    else $error("fired slot still valid");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten before transfer");

endmodule
`default_nettype wire
